// ===== sv/stb_pkg.sv =====
// shared types, constants and command codes for the soft timer bank
package stb_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MAX_OUT     = 8;
  localparam int FIRE_CNT_W  = $clog2(MAX_OUT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;

  // input kind codes
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_SERVICE = 3'd1;
  localparam logic [2:0] KIND_ARM     = 3'd2;
  localparam logic [2:0] KIND_DISARM  = 3'd3;
  localparam logic [2:0] KIND_QUERY   = 3'd4;

  // result kind codes
  localparam logic RES_FIRED = 1'b0;
  localparam logic RES_QUERY = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SERVICE,
    OP_ARM,
    OP_DISARM,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  timer_index;
    logic        in_range;
    logic [31:0] timeout;
    logic [31:0] repeat_count;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } eng_state_t;

endpackage

// ===== sv/stb_front.sv =====
// front end: accepts input items, decodes kind and drops items with no effect
module stb_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           kind,
  input  logic [2:0]           timer_index,
  input  logic [31:0]          timeout,
  input  logic [31:0]          repeat_count,
  input  logic                 q_full,
  output logic                 q_push,
  output stb_pkg::cmd_t        q_cmd
);

  logic       in_range;
  logic       keep;
  stb_pkg::op_t op;

  assign in_range = 32'(timer_index) < 32'(stb_pkg::NUM_TIMERS);

  always_comb begin
    op   = stb_pkg::OP_TICK;
    keep = 1'b0;
    unique case (kind)
      stb_pkg::KIND_TICK: begin
        op   = stb_pkg::OP_TICK;
        keep = 1'b1;
      end
      stb_pkg::KIND_SERVICE: begin
        op   = stb_pkg::OP_SERVICE;
        keep = 1'b1;
      end
      stb_pkg::KIND_ARM: begin
        op   = stb_pkg::OP_ARM;
        keep = in_range;
      end
      stb_pkg::KIND_DISARM: begin
        op   = stb_pkg::OP_DISARM;
        keep = in_range;
      end
      stb_pkg::KIND_QUERY: begin
        op   = stb_pkg::OP_QUERY;
        keep = 1'b1;
      end
      default: begin
        op   = stb_pkg::OP_TICK;
        keep = 1'b0;
      end
    endcase
  end

  // dropped items are still taken, so ready only follows queue space
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && keep;

  always_comb begin
    q_cmd.op           = op;
    q_cmd.timer_index  = timer_index;
    q_cmd.in_range     = in_range;
    q_cmd.timeout      = timeout;
    q_cmd.repeat_count = repeat_count;
  end

endmodule

// ===== sv/stb_queue.sv =====
// short command queue between front end and timer engine
module stb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  stb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output stb_pkg::cmd_t head_cmd
);

  stb_pkg::cmd_t                 entries [stb_pkg::QUEUE_DEPTH];
  logic [stb_pkg::QPTR_W-1:0]    wr_ptr;
  logic [stb_pkg::QPTR_W-1:0]    rd_ptr;
  logic [stb_pkg::QCNT_W-1:0]    fill;

  function automatic logic [stb_pkg::QPTR_W-1:0] bump(input logic [stb_pkg::QPTR_W-1:0] p);
    logic [stb_pkg::QPTR_W-1:0] r;
    if (p == stb_pkg::QPTR_W'(stb_pkg::QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign full       = fill == stb_pkg::QCNT_W'(stb_pkg::QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// ===== sv/stb_engine.sv =====
// timer engine: timer state, per-timer scan for tick and service, result register
module stb_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  stb_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          result_kind,
  output logic [2:0]    which_timer,
  output logic [31:0]   count_value,
  output logic          is_armed,
  output logic          last
);

  localparam logic [stb_pkg::TIMER_IDX_W-1:0] LAST_IDX =
    stb_pkg::TIMER_IDX_W'(stb_pkg::NUM_TIMERS - 1);

  stb_pkg::eng_state_t state, state_next;

  logic [stb_pkg::NUM_TIMERS-1:0] armed;
  logic [31:0] counters [stb_pkg::NUM_TIMERS];
  logic [31:0] timeouts [stb_pkg::NUM_TIMERS];
  logic [31:0] repeats  [stb_pkg::NUM_TIMERS];

  logic [stb_pkg::TIMER_IDX_W-1:0] scan_idx;
  logic [stb_pkg::FIRE_CNT_W-1:0]  fire_cnt;
  logic                            pend_valid;
  logic [2:0]                      pend_which;
  logic                            pend_armed;

  logic [stb_pkg::TIMER_IDX_W-1:0] rd_idx;
  logic        armed_rd;
  logic [31:0] cnt_rd, tmo_rd, rep_rd, rep_dec, rep_new;
  logic        armed_new;
  logic        fire, fire_go, fire_cap, scan_end, out_free;

  // control decode
  logic        arm_we, disarm_we, tick_we, fire_we, idx_inc;
  logic        load, load_kind, load_armed, load_last;
  logic [2:0]  load_which;
  logic [31:0] load_count;

  assign rd_idx   = (state == stb_pkg::ST_IDLE) ?
                    stb_pkg::TIMER_IDX_W'(cmd.timer_index) : scan_idx;
  assign armed_rd = armed[rd_idx];
  assign cnt_rd   = counters[rd_idx];
  assign tmo_rd   = timeouts[rd_idx];
  assign rep_rd   = repeats[rd_idx];

  assign rep_dec   = rep_rd - 32'd1;
  assign rep_new   = (rep_rd == stb_pkg::FOREVER) ? rep_rd : rep_dec;
  assign armed_new = (rep_rd == stb_pkg::FOREVER) || (rep_dec != 32'd0);

  assign out_free = !out_valid || out_ready;
  assign scan_end = scan_idx == LAST_IDX;
  assign fire     = (cmd.op == stb_pkg::OP_SERVICE) && armed_rd && (cnt_rd >= tmo_rd);
  // a held result must leave before the next firing can take its place
  assign fire_go  = fire && (!pend_valid || out_free);
  assign fire_cap = fire_cnt == stb_pkg::FIRE_CNT_W'(stb_pkg::MAX_OUT - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      stb_pkg::ST_IDLE: begin
        if (cmd_valid &&
            (cmd.op == stb_pkg::OP_TICK || cmd.op == stb_pkg::OP_SERVICE)) begin
          state_next = stb_pkg::ST_SCAN;
        end
      end
      stb_pkg::ST_SCAN: begin
        if (cmd.op == stb_pkg::OP_TICK) begin
          if (scan_end) state_next = stb_pkg::ST_IDLE;
        end else if (fire) begin
          if (fire_go && (fire_cap || scan_end)) state_next = stb_pkg::ST_FLUSH;
        end else if (scan_end) begin
          state_next = pend_valid ? stb_pkg::ST_FLUSH : stb_pkg::ST_IDLE;
        end
      end
      stb_pkg::ST_FLUSH: begin
        if (out_free) state_next = stb_pkg::ST_IDLE;
      end
      default: state_next = stb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    arm_we     = 1'b0;
    disarm_we  = 1'b0;
    tick_we    = 1'b0;
    fire_we    = 1'b0;
    idx_inc    = 1'b0;
    load       = 1'b0;
    load_kind  = stb_pkg::RES_FIRED;
    load_which = pend_which;
    load_count = 32'd0;
    load_armed = pend_armed;
    load_last  = 1'b0;
    unique case (state)
      stb_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            stb_pkg::OP_ARM: begin
              arm_we  = 1'b1;
              cmd_pop = 1'b1;
            end
            stb_pkg::OP_DISARM: begin
              disarm_we = 1'b1;
              cmd_pop   = 1'b1;
            end
            stb_pkg::OP_QUERY: begin
              if (out_free) begin
                load       = 1'b1;
                load_kind  = stb_pkg::RES_QUERY;
                load_which = cmd.timer_index;
                load_count = cmd.in_range ? cnt_rd : 32'd0;
                load_armed = cmd.in_range && armed_rd;
                load_last  = 1'b1;
                cmd_pop    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      stb_pkg::ST_SCAN: begin
        if (cmd.op == stb_pkg::OP_TICK) begin
          tick_we = armed_rd;
          idx_inc = !scan_end;
          cmd_pop = scan_end;
        end else if (fire) begin
          if (fire_go) begin
            fire_we = 1'b1;
            load    = pend_valid;
            idx_inc = !scan_end;
          end
        end else begin
          idx_inc = !scan_end;
          cmd_pop = scan_end && !pend_valid;
        end
      end
      stb_pkg::ST_FLUSH: begin
        if (out_free) begin
          load      = 1'b1;
          load_last = 1'b1;
          cmd_pop   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
      for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
        counters[i] <= 32'd0;
      end
    end else begin
      if (arm_we) begin
        armed[rd_idx]    <= 1'b1;
        counters[rd_idx] <= 32'd0;
      end else if (disarm_we) begin
        armed[rd_idx]    <= 1'b0;
        counters[rd_idx] <= 32'd0;
      end else if (tick_we) begin
        counters[rd_idx] <= cnt_rd + 32'd1;
      end else if (fire_we) begin
        armed[rd_idx]    <= armed_new;
        counters[rd_idx] <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (arm_we) begin
      timeouts[rd_idx] <= cmd.timeout;
      repeats[rd_idx]  <= cmd.repeat_count;
    end else if (fire_we) begin
      repeats[rd_idx] <= rep_new;
    end
  end

  // scan position, firing count and the held result of the last firing
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      fire_cnt   <= '0;
      pend_valid <= 1'b0;
    end else if (state == stb_pkg::ST_IDLE) begin
      scan_idx   <= '0;
      fire_cnt   <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (idx_inc) scan_idx <= scan_idx + 1'b1;
      if (fire_we) begin
        fire_cnt   <= fire_cnt + 1'b1;
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_we) begin
      pend_which <= 3'(scan_idx);
      pend_armed <= armed_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= load_kind;
      which_timer <= load_which;
      count_value <= load_count;
      is_armed    <= load_armed;
      last        <= load_last;
    end
  end

endmodule

// ===== sv/soft_timer_bank.sv =====
// soft timer bank top level: front end, command queue and timer engine
// arm, disarm and query are taken from the queue while the engine is idle; a query waits for a free result register
// tick and service: dispatched from idle, then a scan over every timer in turn
// a service that fires ends in a flush state for its final result, which waits out any output stalls
// the engine takes no new item until the last is through, set by the single compare and update unit
// synchronous active-high reset clears armed flags, counters, queue and output
module soft_timer_bank (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [2:0]  timer_index,
  input  logic [31:0] timeout,
  input  logic [31:0] repeat_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [2:0]  which_timer,
  output logic [31:0] count_value,
  output logic        is_armed,
  output logic        last
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_head_valid;
  stb_pkg::cmd_t q_push_cmd;
  stb_pkg::cmd_t q_head_cmd;

  stb_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .timer_index  (timer_index),
    .timeout      (timeout),
    .repeat_count (repeat_count),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_push_cmd)
  );

  stb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  stb_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_head_valid),
    .cmd         (q_head_cmd),
    .cmd_pop     (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .which_timer (which_timer),
    .count_value (count_value),
    .is_armed    (is_armed),
    .last        (last)
  );

endmodule

// ===== sv/stb_checker.sv =====
// port-level checks for the soft timer bank, bound to the top level
module stb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [2:0]  which_timer,
  input logic [31:0] count_value,
  input logic        is_armed,
  input logic        last
);

  // no result is shown in the cycle after reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a query answer is always the only result of its item
  a_query_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == stb_pkg::RES_QUERY |-> last)
    else $error("query answer without last");

  // a fired timer reports its cleared counter
  a_fired_count_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == stb_pkg::RES_FIRED |-> count_value == 32'd0)
    else $error("fired result with nonzero count");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(which_timer) &&
      $stable(is_armed) && $stable(last) && $stable(result_kind))
    else $error("stalled result changed");

endmodule

bind soft_timer_bank stb_checker u_stb_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_kind (result_kind),
  .which_timer (which_timer),
  .count_value (count_value),
  .is_armed    (is_armed),
  .last        (last)
);

// ===== bench/timer_bank_checker.sv =====
// transfer monitor, timer bank predictor and result comparison for the soft timer bank
`timescale 1ns / 1ps

module timer_bank_checker
  import stb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [2:0]  timer_index,
  input  logic [31:0] timeout,
  input  logic [31:0] repeat_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        result_kind,
  input  logic [2:0]  which_timer,
  input  logic [31:0] count_value,
  input  logic        is_armed,
  input  logic        last,
  output int          failures,
  output int          pending
);

  localparam int SHOW_LIMIT = 100;

  typedef struct packed {
    logic        rkind;
    logic [2:0]  idx;
    logic [31:0] cnt;
    logic        armed;
    logic        last;
  } timer_result_t;

  logic        armed_now  [NUM_TIMERS];
  logic [31:0] tick_count [NUM_TIMERS];
  logic [31:0] fire_at    [NUM_TIMERS];
  logic [31:0] firings_left [NUM_TIMERS];

  timer_result_t awaited_results[$];
  int shown;

  initial begin
    failures = 0;
    pending  = 0;
    shown    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    failures++;
    if (shown < SHOW_LIMIT)
      $display("%0t ns: mismatch on %0s, expected %0h, got %0h", $time, what, want, got);
    shown++;
  endtask

  task automatic clear_bank();
    int i;
    for (i = 0; i < NUM_TIMERS; i++) begin
      armed_now[i]    = 1'b0;
      tick_count[i]   = '0;
      fire_at[i]      = '0;
      firings_left[i] = '0;
    end
    awaited_results.delete();
  endtask

  // update the bank for one accepted command and queue the results it causes
  task automatic apply_command(input logic [2:0] k, input logic [2:0] idx,
                               input logic [31:0] tmo, input logic [31:0] rep);
    timer_result_t batch [MAX_OUT];
    int fired;
    int i;
    bit in_bank;
    fired   = 0;
    in_bank = int'(idx) < NUM_TIMERS;
    case (k)
      KIND_TICK: begin
        for (i = 0; i < NUM_TIMERS; i++)
          if (armed_now[i]) tick_count[i] = tick_count[i] + 32'd1;
      end
      KIND_SERVICE: begin
        for (i = 0; i < NUM_TIMERS; i++) begin
          if (fired < MAX_OUT && armed_now[i] && tick_count[i] >= fire_at[i]) begin
            tick_count[i] = '0;
            if (firings_left[i] != FOREVER) begin
              firings_left[i] = firings_left[i] - 32'd1;
              if (firings_left[i] == '0) armed_now[i] = 1'b0;
            end
            batch[fired] = '{RES_FIRED, 3'(i), 32'd0, armed_now[i], 1'b0};
            fired++;
          end
        end
      end
      KIND_ARM: begin
        if (in_bank) begin
          armed_now[idx]    = 1'b1;
          fire_at[idx]      = tmo;
          tick_count[idx]   = '0;
          firings_left[idx] = rep;
        end
      end
      KIND_DISARM: begin
        if (in_bank) begin
          armed_now[idx]  = 1'b0;
          tick_count[idx] = '0;
        end
      end
      KIND_QUERY: begin
        if (in_bank)
          batch[0] = '{RES_QUERY, idx, tick_count[idx], armed_now[idx], 1'b0};
        else
          batch[0] = '{RES_QUERY, idx, 32'd0, 1'b0, 1'b0};
        fired = 1;
      end
      default: ;
    endcase
    if (fired > 0) batch[fired - 1].last = 1'b1;
    for (i = 0; i < fired; i++) awaited_results.push_back(batch[i]);
  endtask

  always @(posedge clk) begin : watch
    timer_result_t want;
    if (rst) begin
      clear_bank();
    end else begin
      // results leave before the command on the same edge could add any
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 32'd0, 32'(which_timer));
        end else begin
          want = awaited_results.pop_front();
          if (result_kind !== want.rkind)
            report_mismatch("result_kind", 32'(want.rkind), 32'(result_kind));
          if (which_timer !== want.idx)
            report_mismatch("which_timer", 32'(want.idx), 32'(which_timer));
          if (count_value !== want.cnt) report_mismatch("count_value", want.cnt, count_value);
          if (is_armed !== want.armed)
            report_mismatch("is_armed", 32'(want.armed), 32'(is_armed));
          if (last !== want.last) report_mismatch("last", 32'(want.last), 32'(last));
        end
      end
      if (in_valid && in_ready) apply_command(kind, timer_index, timeout, repeat_count);
    end
    pending = awaited_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
// top-level bench for the soft timer bank: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
  import stb_pkg::*;

  localparam int ITEM_COUNT   = 430;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 4 * (NUM_TIMERS + 2) + 8;
  localparam int PAUSE_EVERY  = 90;
  localparam int CALM_EVERY   = 60;
  localparam logic [2:0] KIND_UNUSED_LO = KIND_QUERY + 3'd1;
  localparam logic [2:0] KIND_UNUSED_HI = '1;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  kind;
  logic [2:0]  timer_index;
  logic [31:0] timeout;
  logic [31:0] repeat_count;
  logic        out_valid;
  logic        out_ready;
  logic        result_kind;
  logic [2:0]  which_timer;
  logic [31:0] count_value;
  logic        is_armed;
  logic        last;

  int failures;
  int pending;
  int quiet_cycles;
  bit calm;

  soft_timer_bank dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .timer_index  (timer_index),
    .timeout      (timeout),
    .repeat_count (repeat_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .which_timer  (which_timer),
    .count_value  (count_value),
    .is_armed     (is_armed),
    .last         (last)
  );

  timer_bank_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .timer_index  (timer_index),
    .timeout      (timeout),
    .repeat_count (repeat_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .which_timer  (which_timer),
    .count_value  (count_value),
    .is_armed     (is_armed),
    .last         (last),
    .failures     (failures),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_command(input logic [2:0] k, input logic [2:0] idx,
                              input logic [31:0] tmo, input logic [31:0] rep);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind         <= k;
    timer_index  <= idx;
    timeout      <= tmo;
    repeat_count <= rep;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off new commands until every outstanding result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly small timeouts and repeat counts so timers really fire and expire
  task automatic send_random_command();
    int pick;
    logic [2:0]  k;
    logic [31:0] tmo;
    logic [31:0] rep;
    pick = $urandom_range(0, 99);
    if (pick < 34)      k = KIND_TICK;
    else if (pick < 52) k = KIND_SERVICE;
    else if (pick < 70) k = KIND_ARM;
    else if (pick < 78) k = KIND_DISARM;
    else if (pick < 94) k = KIND_QUERY;
    else                k = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    tmo = $urandom;
    rep = $urandom;
    if (k == KIND_ARM) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) tmo = $urandom_range(0, 8);
      else if (pick < 85) tmo = FOREVER;
      pick = $urandom_range(0, 99);
      if (pick < 40)      rep = $urandom_range(1, 3);
      else if (pick < 55) rep = '0;
      else if (pick < 75) rep = FOREVER;
    end
    send_command(k, 3'($urandom_range(0, 7)), tmo, rep);
  endtask

  initial begin
    int n;
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_TICK;
    timer_index  = '0;
    timeout      = '0;
    repeat_count = '0;
    calm         = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed: fresh queries, empty service, edge values, repeat zero, wraps
    send_command(KIND_QUERY, 3'd0, 32'd0, 32'd0);
    send_command(KIND_QUERY, 3'd7, FOREVER, FOREVER);
    send_command(KIND_SERVICE, 3'd0, 32'd0, 32'd0);
    send_command(KIND_ARM, 3'd0, 32'd0, FOREVER);
    send_command(KIND_ARM, 3'd7, FOREVER, 32'd1);
    send_command(KIND_ARM, 3'd1, 32'd2, 32'd0);
    send_command(KIND_ARM, 3'd2, 32'd1, 32'd1);
    send_command(KIND_TICK, 3'd0, 32'd0, 32'd0);
    send_command(KIND_TICK, 3'd7, FOREVER, FOREVER);
    send_command(KIND_QUERY, 3'd1, 32'd0, 32'd0);
    send_command(KIND_SERVICE, 3'd0, 32'd0, 32'd0);
    send_command(KIND_SERVICE, 3'd7, FOREVER, FOREVER);
    send_command(KIND_DISARM, 3'd0, 32'd0, 32'd0);
    send_command(KIND_QUERY, 3'd0, 32'd0, 32'd0);
    send_command(KIND_UNUSED_LO, 3'd7, FOREVER, FOREVER);
    send_command(KIND_UNUSED_HI, 3'd0, 32'd0, 32'd0);
    for (n = 0; n < NUM_TIMERS; n++) send_command(KIND_ARM, 3'(n), 32'd0, 32'd2);
    send_command(KIND_SERVICE, 3'd0, 32'd0, 32'd0);
    drain_results();

    for (n = 0; n < ITEM_COUNT; n++) begin
      if (n % CALM_EVERY == 0) calm = ($urandom_range(0, 2) == 0);
      if (n > 0 && n % PAUSE_EVERY == 0) drain_results();
      send_random_command();
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
sv/stb_pkg.sv
sv/stb_front.sv
sv/stb_queue.sv
sv/stb_engine.sv
sv/soft_timer_bank.sv
sv/stb_checker.sv
bench/timer_bank_checker.sv
bench/testbench.sv
